/* rtl/fwa_pkg.sv */
// Shared types, constants and coefficient tables of the frame window block.
package fwa_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 13;
    localparam int POS_W      = 12;
    localparam int MAX_FRAME  = 4096;
    localparam int TURN_W     = 24;
    localparam int DIV_N_W    = 36;
    localparam int DIV_D_W    = 12;
    localparam int DIV_CNT_W  = 6;
    localparam int DIV_STEPS  = 36;
    localparam int TAYLOR_N   = 6;
    localparam int FIFO_DEPTH = 2;

    // Register indexes of the configuration port.
    localparam logic CFG_WINDOW_KIND  = 1'b0;
    localparam logic CFG_FRAME_LENGTH = 1'b1;

    // Window kinds; both codes with the upper bit set select Blackman.
    localparam logic [KIND_W-1:0] KIND_HANN    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HAMMING = 2'd1;

    // Pi and one in Q30.
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // One accepted sample with its frame position, as queued for the back end.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [POS_W-1:0]           pos;
        logic [POS_W-1:0]           span;
        logic [KIND_W-1:0]          kind;
        logic                       last;
    } fwa_item_t;

    // Request to the phase divider.
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } fwa_div_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_TURN,
        ST_MUL_X,
        ST_MUL_X2,
        ST_TAYLOR_INIT,
        ST_MUL_F,
        ST_RECIP_MUL,
        ST_RECIP_FIN,
        ST_MUL_FIN,
        ST_COS,
        ST_MUL_W,
        ST_ACC,
        ST_COEF,
        ST_MUL_S,
        ST_OUT
    } fwa_state_t;

    // Division by the Taylor divisors (2k-1)*2k, k from seven down to two, is
    // a multiply by 2^(32+s)/divisor rounded up, then a shift right by 32+s.
    // The reciprocal always has bit 32 set; this table holds its low 32 bits.
    // The result is exact for every 32-bit dividend.
    function automatic logic [31:0] taylor_recip(input logic [2:0] idx);
        logic [31:0] m;
        case (idx)
            3'd0:    m = 32'd1746305385;
            3'd1:    m = 32'd4034666248;
            3'd2:    m = 32'd1813430637;
            3'd3:    m = 32'd613566757;
            3'd4:    m = 32'd286331154;
            default: m = 32'd1431655766;
        endcase
        return m;
    endfunction

    // Extra shift s that goes with each reciprocal.
    function automatic logic [3:0] taylor_shift(input logic [2:0] idx);
        logic [3:0] s;
        case (idx)
            3'd0:    s = 4'd8;
            3'd1:    s = 4'd8;
            3'd2:    s = 4'd7;
            3'd3:    s = 4'd6;
            3'd4:    s = 4'd5;
            default: s = 4'd4;
        endcase
        return s;
    endfunction

    // Constant term of the window, Q30.
    function automatic logic [29:0] win_a(input logic [KIND_W-1:0] kind);
        logic [29:0] v;
        case (kind)
            KIND_HANN:    v = 30'd536870912;
            KIND_HAMMING: v = 30'd579820585;
            default:      v = 30'd450971566;
        endcase
        return v;
    endfunction

    // Weight of the first cosine, Q30.
    function automatic logic [29:0] win_b(input logic [KIND_W-1:0] kind);
        logic [29:0] v;
        case (kind)
            KIND_HAMMING: v = 30'd493921239;
            default:      v = 30'd536870912;
        endcase
        return v;
    endfunction

    // Weight of the second cosine, Q30; only Blackman uses it.
    function automatic logic [29:0] win_c(input logic [KIND_W-1:0] kind);
        logic [29:0] v;
        case (kind) inside
            KIND_HANN, KIND_HAMMING: v = 30'd0;
            default:                 v = 30'd85899346;
        endcase
        return v;
    endfunction

endpackage

/* rtl/frame_window_apply_core.sv */
// Top level of the frame window block: front end, queue and back end.
//
// Each 16-bit signed sample is multiplied by a Hann, Hamming or Blackman
// coefficient for its position in the frame, at phase position/(length-1),
// and returned with the Q1.15 coefficient used and a flag on the last sample
// of the frame. One sample is worked at a time. The time a sample takes is
// set by the one-bit-per-cycle phase divider, which is skipped for a frame
// length of one, by the cosine series on one shared multiplier, of which
// Blackman needs two cosines, and by any wait for the output register. Two
// further samples can wait in the queue, and a finished word waits in the
// output register without stopping the next sample.
// Configuration is to be written while no sample is in flight; the block
// itself does not enforce this.
module frame_window_apply_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [fwa_pkg::LEN_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] sample_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [15:0] sample_out, [31:16] coefficient
    output logic                          m_tlast    // frame_last
);
    import fwa_pkg::*;

    fwa_item_t push_item;
    fwa_item_t pop_item;
    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_empty;

    fwa_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .push        (push),
        .push_item   (push_item),
        .queue_full  (queue_full)
    );

    fwa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    fwa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_item    (pop_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

/* rtl/fwa_div.sv */
// Restoring divider, one quotient bit per cycle, for the frame phase of the back end.
module fwa_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fwa_pkg::fwa_div_req_t         req,
    output logic [fwa_pkg::DIV_N_W-1:0]   quotient,
    output logic                          done
);
    import fwa_pkg::*;

    logic [DIV_N_W-1:0]   work_reg, work_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign shifted = {rem_reg, work_reg[DIV_N_W-1]};
    assign ge      = shifted >= {1'b0, divisor_reg};
    assign diff    = shifted - {1'b0, divisor_reg};

    always_comb begin
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start) begin
            work_next    = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            work_next = {work_reg[DIV_N_W-2:0], ge};
            rem_next  = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign quotient = work_reg;
    assign done     = done_reg;

`ifndef SYNTHESIS
    // The partial remainder always stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < divisor_reg))
        else $error("divider remainder reached the divisor");

    // Completion is flagged only once the unit has gone idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
`endif

endmodule

/* rtl/fwa_fifo.sv */
// Two-entry queue between the front end and the back end.
module fwa_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fwa_pkg::fwa_item_t push_item,
    input  logic               pop,
    output fwa_pkg::fwa_item_t pop_item,
    output logic               full,
    output logic               empty
);
    import fwa_pkg::*;

    fwa_item_t  mem_reg [FIFO_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = count_reg == 2'(FIFO_DEPTH);
    assign empty    = count_reg == 2'd0;
    assign pop_item = mem_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    // The front end must hold off while the queue is full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into a full queue");

    // The back end must only take entries that exist.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from an empty queue");
`endif

endmodule

/* rtl/fwa_front.sv */
// Front end: configuration registers, frame position tracking and sample intake.
module fwa_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [fwa_pkg::LEN_W-1:0]         cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fwa_pkg::SAMPLE_W-1:0]      s_tdata,
    output logic                              push,
    output fwa_pkg::fwa_item_t                push_item,
    input  logic                              queue_full
);
    import fwa_pkg::*;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [LEN_W-1:0]  len_eff;
    logic [POS_W-1:0]  span;
    logic              last;

    // Configuration writes.
    always_comb begin
        kind_next   = kind_reg;
        length_next = length_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WINDOW_KIND:  kind_next   = cfg_wr_data[KIND_W-1:0];
                default:          length_next = cfg_wr_data;
            endcase
        end
    end

    // Effective frame length: zero acts as one, long frames are capped.
    always_comb begin
        if (length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (length_reg > LEN_W'(MAX_FRAME)) begin
            len_eff = LEN_W'(MAX_FRAME);
        end else begin
            len_eff = length_reg;
        end
        span = POS_W'(len_eff - LEN_W'(1));
        last = position_reg >= span;
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    // Queue entry for the back end.
    always_comb begin
        push_item.sample = s_tdata;
        push_item.pos    = last ? span : position_reg;
        push_item.span   = span;
        push_item.kind   = kind_reg;
        push_item.last   = last;
    end

    assign position_next = !push ? position_reg :
                           (last ? '0 : position_reg + POS_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= KIND_HANN;
            length_reg   <= LEN_W'(1024);
            position_reg <= '0;
        end else begin
            kind_reg     <= kind_next;
            length_reg   <= length_next;
            position_reg <= position_next;
        end
    end

endmodule

/* rtl/fwa_back.sv */
// Back end: phase division, cosine series, window sum and sample scaling.
module fwa_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fwa_pkg::fwa_item_t             pop_item,
    input  logic                           queue_empty,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,
    output logic                           m_tlast
);
    import fwa_pkg::*;

    fwa_state_t           state_reg, state_next;
    logic signed [15:0]   sample_reg, sample_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic                 last_reg, last_next;
    logic [TURN_W:0]      t_reg, t_next;
    logic                 pass_reg, pass_next;
    logic [22:0]          r_reg, r_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          x2_reg, x2_next;
    logic [30:0]          f_reg, f_next;
    logic [2:0]           k_reg, k_next;
    logic [31:0]          num_reg, num_next;
    logic signed [31:0]   cos_reg, cos_next;
    logic signed [63:0]   acc_reg, acc_next;
    logic [COEF_W-1:0]    coef_reg, coef_next;
    logic signed [65:0]   mul_p_reg;
    logic signed [32:0]   mul_a, mul_b;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    fwa_div_req_t         div_req;
    logic [DIV_N_W-1:0]   div_quot;
    logic                 div_done;

    logic [TURN_W-1:0]    u;
    logic [31:0]          half;
    logic [31:0]          c32;
    logic [64:0]          recip_sum;
    logic [32:0]          recip_quot;
    logic [63:0]          w_pos;
    logic [63:0]          w_sum;
    logic [18:0]          coef_wide;
    logic signed [33:0]   v;
    logic signed [18:0]   y_wide;
    logic [15:0]          y;
    logic                 out_free;

    fwa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .quotient (div_quot),
        .done     (div_done)
    );

    // Shared signed multiplier, product registered.
    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
    end

    // Helper terms of the datapath.
    always_comb begin
        u          = pass_reg ? {t_reg[TURN_W-2:0], 1'b0} : t_reg[TURN_W-1:0];
        half       = {1'b0, mul_p_reg[61:31]};
        c32        = {1'b0, Q30_ONE} - half;
        // The reciprocal's implied bit 32 adds the dividend shifted up by 32.
        recip_sum  = {1'b0, num_reg, 32'd0} + {1'b0, mul_p_reg[63:0]};
        recip_quot = recip_sum[64:32] >> taylor_shift(k_reg);
        w_pos      = acc_reg[63] ? 64'd0 : acc_reg;
        w_sum      = w_pos + (64'd1 << 44);
        coef_wide  = w_sum[63:45];
        v          = mul_p_reg[33:0] + 34'sd16384;
        y_wide     = v[33:15];
        if (y_wide > 19'sd32767) begin
            y = 16'h7FFF;
        end else if (y_wide < -19'sd32768) begin
            y = 16'h8000;
        end else begin
            y = y_wide[15:0];
        end
        out_free = !out_valid_reg || m_tready;
    end

    // Sequencer: next state, operand selection and register updates.
    always_comb begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        t_next         = t_reg;
        pass_next      = pass_reg;
        r_next         = r_reg;
        neg_next       = neg_reg;
        x2_next        = x2_reg;
        f_next         = f_reg;
        k_next         = k_reg;
        num_next       = num_reg;
        cos_next       = cos_reg;
        acc_next       = acc_reg;
        coef_next      = coef_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop            = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    pop         = 1'b1;
                    sample_next = pop_item.sample;
                    kind_next   = pop_item.kind;
                    last_next   = pop_item.last;
                    pass_next   = 1'b0;
                    if (pop_item.span == '0) begin
                        t_next     = '0;
                        state_next = ST_TURN;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {pop_item.pos, {TURN_W{1'b0}}};
                        div_req.divisor  = pop_item.span;
                        state_next       = ST_PHASE;
                    end
                end
            end
            ST_PHASE: begin
                if (div_done) begin
                    t_next     = div_quot[TURN_W:0];
                    state_next = ST_TURN;
                end
            end
            ST_TURN: begin
                // Fold the turn into a quarter and note the sign of the cosine.
                r_next     = u[22] ? (23'h40_0000 - {1'b0, u[21:0]}) : {1'b0, u[21:0]};
                neg_next   = u[23] ^ u[22];
                state_next = ST_MUL_X;
            end
            ST_MUL_X: begin
                mul_a      = {10'd0, r_reg};
                mul_b      = {1'b0, PI_Q30};
                state_next = ST_MUL_X2;
            end
            ST_MUL_X2: begin
                mul_a      = {2'd0, mul_p_reg[53:23]};
                mul_b      = {2'd0, mul_p_reg[53:23]};
                state_next = ST_TAYLOR_INIT;
            end
            ST_TAYLOR_INIT: begin
                x2_next    = mul_p_reg[61:30];
                f_next     = Q30_ONE;
                k_next     = '0;
                state_next = ST_MUL_F;
            end
            ST_MUL_F: begin
                mul_a      = {1'b0, x2_reg};
                mul_b      = {2'd0, f_reg};
                state_next = ST_RECIP_MUL;
            end
            ST_RECIP_MUL: begin
                // Divide the series term by multiplying with the scaled reciprocal.
                num_next   = mul_p_reg[61:30];
                mul_a      = {1'b0, mul_p_reg[61:30]};
                mul_b      = {1'b0, taylor_recip(k_reg)};
                state_next = ST_RECIP_FIN;
            end
            ST_RECIP_FIN: begin
                f_next = Q30_ONE - recip_quot[30:0];
                if (k_reg == 3'(TAYLOR_N - 1)) begin
                    state_next = ST_MUL_FIN;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_MUL_F;
                end
            end
            ST_MUL_FIN: begin
                mul_a      = {1'b0, x2_reg};
                mul_b      = {2'd0, f_reg};
                state_next = ST_COS;
            end
            ST_COS: begin
                cos_next   = neg_reg ? -$signed(c32) : $signed(c32);
                state_next = ST_MUL_W;
            end
            ST_MUL_W: begin
                mul_a      = pass_reg ? {3'd0, win_c(kind_reg)} : {3'd0, win_b(kind_reg)};
                mul_b      = {cos_reg[31], cos_reg};
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // First pass subtracts the first cosine, second adds the double-angle one.
                if (!pass_reg) begin
                    acc_next = $signed({4'd0, win_a(kind_reg), 30'd0}) - mul_p_reg[63:0];
                end else begin
                    acc_next = acc_reg + mul_p_reg[63:0];
                end
                if (!pass_reg && kind_reg[1]) begin
                    pass_next  = 1'b1;
                    state_next = ST_TURN;
                end else begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF: begin
                coef_next  = (coef_wide > 19'd32768) ? 16'h8000 : coef_wide[15:0];
                state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                mul_a      = {{17{sample_reg[15]}}, sample_reg};
                mul_b      = {17'd0, coef_reg};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Keep the scaled sample in the product register while waiting.
                mul_a = {{17{sample_reg[15]}}, sample_reg};
                mul_b = {17'd0, coef_reg};
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {coef_reg, y};
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
        t_reg        <= t_next;
        pass_reg     <= pass_next;
        r_reg        <= r_next;
        neg_reg      <= neg_next;
        x2_reg       <= x2_next;
        f_reg        <= f_next;
        k_reg        <= k_next;
        num_reg      <= num_next;
        cos_reg      <= cos_next;
        acc_reg      <= acc_next;
        coef_reg     <= coef_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
